// ===== rtl/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants of the exhaustive tour search unit
// Opcodes, fixed field widths, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ets_pkg;

   localparam int CityW   = 4;
   localparam int DistInW = 16;
   localparam int LenW    = 19;
   localparam int PosW    = 3;
   localparam int CountW  = 4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic mem_write;   // store one pair distance
      logic start;       // latch city count, seed order 1..n
      logic issue_leg;   // read the next leg distance
      logic eval;        // compare tour sum against kept extremes
      logic first;       // eval of the very first order
      logic emit_step;   // result transfer done, advance position
   } ets_cmd_type;

   typedef struct packed {
      logic leg_last;    // leg being issued closes the tour
      logic has_next;    // another permutation follows
      logic emit_last;   // result at the final position
   } ets_status_type;

endpackage

// ===== rtl/exhaustive_tour_search_unit.sv =====
// ----------------------------------------------------------------------------
// Load items may arrive back to back; a pair distance is stored once for
// both directions. A start item searches all n! orders of the first n
// cities (n = city_count clamped to 1..MAX_CITIES): each order walks its n
// legs, one leg distance read per cycle from the distance memory, then a
// sum step and a compare step; after the search come n result transfers,
// one per city position. No new item is taken until the last result of a
// search has transferred.
// ----------------------------------------------------------------------------
// exhaustive_tour_search_unit: shortest and longest closed tour by brute force
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module exhaustive_tour_search_unit #(
   parameter int MAX_CITIES = 8,
   parameter int DIST_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [ets_pkg::CountW-1:0]  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [ets_pkg::CityW-1:0]   req_city_a,
   input  logic [ets_pkg::CityW-1:0]   req_city_b,
   input  logic [ets_pkg::DistInW-1:0] req_distance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ets_pkg::PosW-1:0]    rsp_position,
   output logic [ets_pkg::CityW-1:0]   rsp_best_city,
   output logic [ets_pkg::CityW-1:0]   rsp_worst_city,
   output logic [ets_pkg::LenW-1:0]    rsp_best_length,
   output logic [ets_pkg::LenW-1:0]    rsp_worst_length,
   output logic                        rsp_last
);
   import ets_pkg::*;

   ets_cmd_type    cmd;
   ets_status_type status;

   ets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   ets_datapath #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_city_a       (req_city_a),
      .req_city_b       (req_city_b),
      .req_distance     (req_distance),
      .rsp_position     (rsp_position),
      .rsp_best_city    (rsp_best_city),
      .rsp_worst_city   (rsp_worst_city),
      .rsp_best_length  (rsp_best_length),
      .rsp_worst_length (rsp_worst_length)
   );

endmodule

// ===== rtl/ets_datapath.sv =====
// ----------------------------------------------------------------------------
// ets_datapath: distance store, tour order and extremes
// Holds the pair distance memory, walks the legs of the current order,
// steps to the next lexicographic order and keeps the best and worst tours.
// ----------------------------------------------------------------------------
module ets_datapath #(
   parameter int MAX_CITIES = 8,
   parameter int DIST_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ets_pkg::ets_cmd_type     cmd,
   output ets_pkg::ets_status_type  status,
   input  logic                     csr_write_enable,
   input  logic [ets_pkg::CountW-1:0]  csr_write_data,
   input  logic [ets_pkg::CityW-1:0]   req_city_a,
   input  logic [ets_pkg::CityW-1:0]   req_city_b,
   input  logic [ets_pkg::DistInW-1:0] req_distance,
   output logic [ets_pkg::PosW-1:0]    rsp_position,
   output logic [ets_pkg::CityW-1:0]   rsp_best_city,
   output logic [ets_pkg::CityW-1:0]   rsp_worst_city,
   output logic [ets_pkg::LenW-1:0]    rsp_best_length,
   output logic [ets_pkg::LenW-1:0]    rsp_worst_length
);
   import ets_pkg::*;

   localparam int IdxW   = $clog2(MAX_CITIES);
   localparam int CntW   = $clog2(MAX_CITIES + 1);
   localparam int Depth  = MAX_CITIES * MAX_CITIES;
   localparam int AddrW  = $clog2(Depth);
   localparam int TotW   = DIST_BITS + $clog2(MAX_CITIES);

   logic [CountW-1:0]    city_count_ff;
   logic [CntW-1:0]      n_in, n_ff;
   logic [CityW-1:0]     order_ff [MAX_CITIES];
   logic [CityW-1:0]     next_order [MAX_CITIES];
   logic [CityW-1:0]     best_order_ff [MAX_CITIES];
   logic [CityW-1:0]     worst_order_ff [MAX_CITIES];
   logic [TotW-1:0]      sum_ff, best_total_ff, worst_total_ff;
   logic [IdxW-1:0]      leg_idx_ff, leg_nxt_idx, pos_ff;
   logic [DIST_BITS-1:0] mem [Depth];
   logic                 valid_ff [Depth];
   logic [DIST_BITS-1:0] rd_data_ff;
   logic                 rd_ok_ff, acc_en_ff;
   logic [CityW-1:0]     ca, cb, wr_lo, wr_hi, rd_lo, rd_hi;
   logic [AddrW-1:0]     wr_addr, rd_addr;
   logic                 wr_ok, has_next;

   // Map an ordered pair (lo < hi, from 1) to its store entry
   function automatic logic [AddrW-1:0] pair_addr(input logic [CityW-1:0] lo,
                                                  input logic [CityW-1:0] hi);
      pair_addr = AddrW'((int'(lo) - 1) * MAX_CITIES + int'(hi) - 1);
   endfunction

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CountW'(8);
      end else if (csr_write_enable) begin
         city_count_ff <= csr_write_data;
      end
   end

   // Clamp city count into 1..MAX_CITIES
   always_comb begin
      priority if (city_count_ff == '0) begin
         n_in = CntW'(1);
      end else if (int'(city_count_ff) > MAX_CITIES) begin
         n_in = CntW'(MAX_CITIES);
      end else begin
         n_in = CntW'(city_count_ff);
      end
   end

   // Load decode: one entry per unordered pair
   assign wr_ok = (req_city_a != req_city_b) && (req_city_a != '0) && (req_city_b != '0)
                  && (int'(req_city_a) <= MAX_CITIES) && (int'(req_city_b) <= MAX_CITIES);
   assign wr_lo = (req_city_a < req_city_b) ? req_city_a : req_city_b;
   assign wr_hi = (req_city_a < req_city_b) ? req_city_b : req_city_a;
   assign wr_addr = pair_addr(wr_lo, wr_hi);

   // Leg read address
   assign leg_nxt_idx = status.leg_last ? '0 : leg_idx_ff + IdxW'(1);
   assign ca    = order_ff[leg_idx_ff];
   assign cb    = order_ff[leg_nxt_idx];
   assign rd_lo = (ca < cb) ? ca : cb;
   assign rd_hi = (ca < cb) ? cb : ca;
   assign rd_addr = pair_addr(rd_lo, rd_hi);

   // Distance memory, read data registered
   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_ok) begin
         mem[wr_addr] <= DIST_BITS'(req_distance);
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Entry valid bits, cleared on reset; invalid entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < Depth; e++) begin
            valid_ff[e] <= 1'b0;
         end
         rd_ok_ff  <= 1'b0;
         acc_en_ff <= 1'b0;
      end else begin
         if (cmd.mem_write && wr_ok) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff  <= valid_ff[rd_addr] && (ca != cb);
         acc_en_ff <= cmd.issue_leg;
      end
   end

   // Next lexicographic order of the first n entries
   always_comb begin
      int pi, pj, src;
      logic found;
      logic [CityW-1:0] sw [MAX_CITIES];
      pi = 0;
      pj = 0;
      found = 1'b0;
      for (int k = 0; k + 1 < MAX_CITIES; k++) begin
         if ((k + 1 < int'(n_ff)) && (order_ff[k] < order_ff[k + 1])) begin
            pi = k;
            found = 1'b1;
         end
      end
      for (int k = 0; k < MAX_CITIES; k++) begin
         if ((k > pi) && (k < int'(n_ff)) && (order_ff[k] > order_ff[pi])) begin
            pj = k;
         end
      end
      for (int k = 0; k < MAX_CITIES; k++) begin
         sw[k] = order_ff[k];
      end
      sw[pi] = order_ff[pj];
      sw[pj] = order_ff[pi];
      for (int k = 0; k < MAX_CITIES; k++) begin
         src = int'(n_ff) + pi - k;
         if ((k > pi) && (k < int'(n_ff)) && (src >= 0) && (src < MAX_CITIES)) begin
            next_order[k] = sw[src];
         end else begin
            next_order[k] = sw[k];
         end
      end
      has_next = found;
   end

   // Order, leg walk, sum and kept extremes
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff       <= n_in;
         for (int k = 0; k < MAX_CITIES; k++) begin
            order_ff[k] <= CityW'(k + 1);
         end
         sum_ff     <= '0;
         leg_idx_ff <= '0;
         pos_ff     <= '0;
      end else begin
         if (cmd.issue_leg) begin
            leg_idx_ff <= leg_idx_ff + IdxW'(1);
         end
         if (acc_en_ff) begin
            sum_ff <= sum_ff + (rd_ok_ff ? TotW'(rd_data_ff) : '0);
         end
         if (cmd.eval) begin
            if (cmd.first || sum_ff < best_total_ff) begin
               best_total_ff <= sum_ff;
               best_order_ff <= order_ff;
            end
            if (cmd.first || sum_ff > worst_total_ff) begin
               worst_total_ff <= sum_ff;
               worst_order_ff <= order_ff;
            end
            if (has_next) begin
               order_ff   <= next_order;
               sum_ff     <= '0;
               leg_idx_ff <= '0;
            end
         end
         if (cmd.emit_step) begin
            pos_ff <= pos_ff + IdxW'(1);
         end
      end
   end

   assign status.leg_last  = (leg_idx_ff == IdxW'(n_ff - CntW'(1)));
   assign status.has_next  = has_next;
   assign status.emit_last = (pos_ff == IdxW'(n_ff - CntW'(1)));

   // Result fields
   assign rsp_position     = PosW'(pos_ff);
   assign rsp_best_city    = best_order_ff[pos_ff];
   assign rsp_worst_city   = worst_order_ff[pos_ff];
   assign rsp_best_length  = LenW'(best_total_ff);
   assign rsp_worst_length = LenW'(worst_total_ff);

endmodule

// ===== rtl/ets_ctrl.sv =====
// ----------------------------------------------------------------------------
// ets_ctrl: sequencing controller of the exhaustive tour search unit
// Takes load and start transfers, steps the leg walk for each order and
// hands out the result transfers.
// ----------------------------------------------------------------------------
module ets_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_last,
   input  ets_pkg::ets_status_type  status,
   output ets_pkg::ets_cmd_type     cmd
);
   import ets_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEG  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       first_ff, first_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_last  = status.emit_last;

   // Commands to the datapath
   always_comb begin
      cmd.mem_write = accept && (req_op == OP_LOAD);
      cmd.start     = accept && (req_op == OP_START);
      cmd.issue_leg = (state_ff == ST_LEG);
      cmd.eval      = (state_ff == ST_EVAL);
      cmd.first     = first_ff;
      cmd.emit_step = rsp_valid && rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_LEG;
               first_in = 1'b1;
            end
         end
         ST_LEG: begin
            if (status.leg_last) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            first_in = 1'b0;
            state_in = status.has_next ? ST_LEG : ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.emit_step && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

endmodule
